FILE: design/skmap_pkg.sv
package skmap_pkg;

  // Fixed field widths of the streamed words
  localparam int unsigned KEY_W     = 8;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned IN_DATA_W = 24;
  localparam int unsigned OUT_DATA_W = 48;

  // Occupancy bitmap: sixteen groups of sixteen keys, one summary bit a group
  localparam int unsigned GROUP_SIZE = 16;
  localparam int unsigned NUM_GROUPS = 16;
  localparam int unsigned GRP_W      = 4;

  // Configuration space
  localparam int unsigned PADDR_W        = 3;
  localparam logic [0:0]  REG_LAST_KEY   = 1'b0;
  localparam logic [7:0]  LAST_KEY_RESET = 8'hFF;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic {
    ST_SEARCH  = 1'b0,
    ST_RESOLVE = 1'b1
  } back_state_e;

  // Classified word handed from the front to the back
  typedef struct packed {
    op_e              op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             err;
  } item_t;

  // Lowest set bit of a group: {found, index}
  function automatic logic [GRP_W:0] lowest_set(input logic [GROUP_SIZE-1:0] bits);
    logic [GRP_W:0] res;
    res = '0;
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (bits[i]) begin
        res = {1'b1, GRP_W'(i)};
      end
    end
    return res;
  endfunction

endpackage

FILE: design/skmap_front.sv
module skmap_front #(
  parameter int unsigned KEYS = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [skmap_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [skmap_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key[7:0], value[23:8]
  input  logic                               s_axis_tuser,  // operation
  // Towards the queue
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output skmap_pkg::item_t                   q_item_o,
  output logic                               map_clear_o
);
  import skmap_pkg::*;

  localparam int unsigned NKEYS = (KEYS < 256) ? KEYS : 256;
  localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(NKEYS - 1);

  logic [KEY_W-1:0] last_key_q;
  logic [KEY_W-1:0] lim;
  logic             reg_sel;
  logic             cfg_wr;
  logic [KEY_W-1:0] in_key;

  // Decode register writes
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_LAST_KEY);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? {24'b0, last_key_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q <= LAST_KEY_RESET;
    end else if (cfg_wr) begin
      last_key_q <= pwdata[KEY_W-1:0];
    end
  end

  // A new last key rebuilds the map
  assign map_clear_o = cfg_wr;

  // Clamp the limit to the storage depth
  assign lim = (last_key_q > KEY_MAX) ? KEY_MAX : last_key_q;

  // Accept and classify
  assign in_key        = s_axis_tdata[KEY_W-1:0];
  assign s_axis_tready = !q_full_i;
  assign q_push_o      = s_axis_tvalid && !q_full_i;

  always_comb begin
    q_item_o.op    = op_e'(s_axis_tuser);
    q_item_o.key   = in_key;
    q_item_o.value = s_axis_tdata[KEY_W +: VAL_W];
    q_item_o.err   = (in_key > lim);
  end

endmodule

FILE: design/skmap_queue.sv
module skmap_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  skmap_pkg::item_t item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output skmap_pkg::item_t item_o
);
  import skmap_pkg::*;

  item_t      slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign item_o  = slot_q[rd_ptr_q];

  // Store words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue fill level out of range");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

endmodule

FILE: design/skmap_back.sv
module skmap_back #(
  parameter int unsigned KEYS        = 256,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                map_clear_i,
  // From the queue
  input  logic                                q_valid_i,
  input  skmap_pkg::item_t                    q_item_i,
  output logic                                q_pop_o,
  // Result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // present[0], stored_value[16:1], next_valid[17], next_key[25:18],
  // first_key[33:26], last_occupied[41:34], empty_res[42], zero fill above
  output logic [skmap_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tuser  // error
);
  import skmap_pkg::*;

  localparam int unsigned NKEYS = (KEYS < 256) ? KEYS : 256;
  localparam int unsigned AW    = $clog2(NKEYS);

  back_state_e state_q, state_d;

  // Occupancy bitmap with one summary bit per group
  logic [NUM_GROUPS-1:0][GROUP_SIZE-1:0] occ_q;
  logic [NUM_GROUPS-1:0]                 summ_q;
  logic [NUM_GROUPS-1:0]                 grp_any;
  logic [KEY_W-1:0]                      first_q, last_q;
  logic                                  empty_q;

  // Value memory
  logic [VALUE_WIDTH-1:0] mem [NKEYS];
  logic [VALUE_WIDTH-1:0] rdata_q;

  // First search step results
  item_t            s1_item_q;
  logic             s1_present_q;
  logic             s1_in_hit_q;
  logic [GRP_W-1:0] s1_in_idx_q;
  logic             s1_grp_hit_q;
  logic [GRP_W-1:0] s1_grp_q;

  // Output register
  logic                  out_valid_q;
  logic                  out_err_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  logic             s1_load, out_load, do_insert, out_free;
  logic [GRP_W-1:0] key_grp, key_bit;
  logic [GRP_W:0]   in_hit, grp_hit, tail_hit;
  logic             cur_present;
  logic             nvalid;
  logic [KEY_W-1:0] nkey;
  logic [VAL_W-1:0] stored;
  logic [VAL_W-1:0] ins_value;

  assign key_grp  = q_item_i.key[KEY_W-1 -: GRP_W];
  assign key_bit  = q_item_i.key[GRP_W-1:0];
  assign out_free = !out_valid_q || m_axis_tready;

  // Control: search step, then resolve step
  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    s1_load  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      ST_SEARCH: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          s1_load = 1'b1;
          state_d = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_SEARCH;
        end
      end
      default: state_d = ST_SEARCH;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SEARCH;
    end else begin
      state_q <= state_d;
    end
  end

  assign do_insert = s1_load && !q_item_i.err && (q_item_i.op == OP_INSERT);

  // Search bits above the key inside its group and among the later groups
  assign in_hit  = lowest_set(occ_q[key_grp] & (16'hFFFE << key_bit));
  assign grp_hit = lowest_set(summ_q & (16'hFFFE << key_grp));
  assign cur_present = !q_item_i.err &&
                       ((q_item_i.op == OP_INSERT) || occ_q[key_grp][key_bit]);

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q    <= q_item_i;
      s1_present_q <= cur_present;
      s1_in_hit_q  <= in_hit[GRP_W] && !q_item_i.err;
      s1_in_idx_q  <= in_hit[GRP_W-1:0];
      s1_grp_hit_q <= grp_hit[GRP_W] && !q_item_i.err;
      s1_grp_q     <= grp_hit[GRP_W-1:0];
    end
  end

  // Update the bitmap and the bounds on insert; drop all on a rebuild
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= '0;
      summ_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      empty_q <= 1'b1;
    end else if (map_clear_i) begin
      occ_q   <= '0;
      summ_q  <= '0;
      first_q <= '0;
      last_q  <= '0;
      empty_q <= 1'b1;
    end else if (do_insert) begin
      occ_q[key_grp][key_bit] <= 1'b1;
      summ_q[key_grp]         <= 1'b1;
      empty_q                 <= 1'b0;
      if (empty_q || (q_item_i.key < first_q)) begin
        first_q <= q_item_i.key;
      end
      if (empty_q || (q_item_i.key > last_q)) begin
        last_q <= q_item_i.key;
      end
    end
  end

  // Value memory: write on insert, read the addressed entry every search step
  always_ff @(posedge clk_i) begin
    if (do_insert) begin
      mem[q_item_i.key[AW-1:0]] <= VALUE_WIDTH'(q_item_i.value);
    end
    if (s1_load) begin
      rdata_q <= mem[q_item_i.key[AW-1:0]];
    end
  end

  // Resolve the successor and assemble the result word
  assign tail_hit  = lowest_set(occ_q[s1_grp_q]);
  assign ins_value = VAL_W'(VALUE_WIDTH'(s1_item_q.value));

  always_comb begin
    nvalid = 1'b0;
    nkey   = '0;
    if (s1_in_hit_q) begin
      nvalid = 1'b1;
      nkey   = {s1_item_q.key[KEY_W-1 -: GRP_W], s1_in_idx_q};
    end else if (s1_grp_hit_q && tail_hit[GRP_W]) begin
      nvalid = 1'b1;
      nkey   = {s1_grp_q, tail_hit[GRP_W-1:0]};
    end
    stored = '0;
    if (s1_present_q) begin
      stored = (s1_item_q.op == OP_INSERT) ? ins_value : VAL_W'(rdata_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_err_q  <= s1_item_q.err;
      out_data_q <= {5'b0, empty_q, last_q, first_q, nkey, nvalid, stored, s1_present_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_any[g] = |occ_q[g];
    end
  end

  a_summary_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    summ_q == grp_any) else $error("group summary out of step with bitmap");
  a_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_q == (summ_q == '0)) else $error("empty flag out of step with bitmap");
  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (first_q <= last_q)) else $error("first key above last key");
  a_search_to_resolve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load |=> (state_q == ST_RESOLVE)) else $error("search step not followed by resolve");
  a_bounds_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_q |-> (occ_q[first_q[KEY_W-1 -: GRP_W]][first_q[GRP_W-1:0]] &&
                  occ_q[last_q[KEY_W-1 -: GRP_W]][last_q[GRP_W-1:0]]))
    else $error("bound key not occupied");

endmodule

FILE: design/sparse_key_map_with_successor.sv
// Path: the queue, the back end's search step, its resolve step, then the output register.
// The back end takes no new word until the last one has passed its search step over the
//   group summary and its resolve step inside the chosen bitmap group; a held output stalls it.
// A two-word queue lets input acceptance run ahead of the back end.
// Reset: occupancy and bounds cleared, last_key 255; a last_key write clears the map.
module sparse_key_map_with_successor #(
  parameter int unsigned KEYS        = 256,
  parameter int unsigned VALUE_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [skmap_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [skmap_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // key[7:0], value[23:8]
  input  logic                               s_axis_tuser,  // operation
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // present[0], stored_value[16:1], next_valid[17], next_key[25:18],
  // first_key[33:26], last_occupied[41:34], empty_res[42], zero fill above
  output logic [skmap_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                               m_axis_tuser   // error
);
  import skmap_pkg::*;

  logic  q_full, q_push, q_pop, q_valid, map_clear;
  item_t q_in, q_out;

  skmap_front #(
    .KEYS (KEYS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_item_o      (q_in),
    .map_clear_o   (map_clear)
  );

  skmap_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  skmap_back #(
    .KEYS        (KEYS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .map_clear_i   (map_clear),
    .q_valid_i     (q_valid),
    .q_item_i      (q_out),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
